/* rtl/core/hvn_pkg.sv */
`default_nettype none

package hvn_pkg;

   // Lattice hash constants
   localparam logic [31:0] HASH_M1   = 32'h7feb352d;
   localparam logic [31:0] HASH_M2   = 32'h846ca68b;
   localparam logic [31:0] MIX_A     = 32'h9e3779b1;
   localparam logic [31:0] MIX_B     = 32'h85ebca77;
   localparam logic [31:0] MIX_S     = 32'hc2b2ae3d;
   localparam logic [31:0] SALT_STEP = 32'd7919;

   // Field and datapath widths
   localparam int COORD_W = 32;
   localparam int NOISE_W = 32;
   localparam int AMP_W   = 17;
   localparam int GAIN_W  = 16;
   localparam int COUNT_W = 4;
   localparam int SALT_W  = 32;
   localparam int OUT_W   = 16;
   localparam int PROD_W  = AMP_W + NOISE_W;

   // Register stages inside one octave lane, input capture to noise out
   localparam int OCT_DEPTH = 11;

   localparam logic [AMP_W-1:0] AMP_ONE = 17'h10000;

   // Configuration port
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_OCTAVE_COUNT = 2'd0;
   localparam reg_index_type REG_OCTAVE_GAIN  = 2'd1;
   localparam reg_index_type REG_NOISE_SALT   = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd3;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd36045;
   localparam logic [SALT_W-1:0]  SALT_RESET  = 32'd0;

   function automatic logic [31:0] fold16(input logic [31:0] v);
      return v ^ (v >> 16);
   endfunction

   // First half of the finalizer: fold by 16, multiply
   function automatic logic [31:0] mix_lo(input logic [31:0] v);
      return fold16(v) * HASH_M1;
   endfunction

   // Second half: fold by 15, multiply (final fold is applied by the caller)
   function automatic logic [31:0] mix_hi(input logic [31:0] v);
      return (v ^ (v >> 15)) * HASH_M2;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/hvn_octave.sv */
`default_nettype none

module hvn_octave import hvn_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int OCTAVE    = 0,
   parameter int PAD       = 0
) (
   input  logic                      clock,
   input  logic signed [COORD_W-1:0] x_coord,
   input  logic signed [COORD_W-1:0] y_coord,
   input  logic [SALT_W-1:0]         noise_salt,
   output logic [NOISE_W-1:0]        noise
);

   localparam int F  = FRAC_BITS;
   localparam int TW = 2 * F;
   localparam int KW = F + 2;
   localparam int PW = 2 * F + 2;
   localparam int WW = F + 1;
   localparam int MW = NOISE_W + WW;
   localparam logic [KW-1:0]     THREE_F  = {2'b11, {F{1'b0}}};
   localparam logic [WW-1:0]     ONE_W    = {1'b1, {F{1'b0}}};
   localparam logic [SALT_W-1:0] OCT_SALT = SALT_W'(OCTAVE) * SALT_STEP;

   logic [63:0]      px;
   logic [63:0]      py;
   logic [31:0]      ix;
   logic [31:0]      iy;
   logic [F-1:0]     tx;
   logic [F-1:0]     ty;

   // stage 1
   logic [31:0]      ax_ff [0:1];
   logic [31:0]      by_ff [1:3][0:1];
   logic [31:0]      salt_ff [1:5];
   logic [TW-1:0]    ttx_ff;
   logic [TW-1:0]    tty_ff;
   logic [F-1:0]     tx_ff;
   logic [F-1:0]     ty_ff;
   // stage 2..3
   logic [31:0]      hx2_ff [0:1];
   logic [31:0]      hx3_ff [0:1];
   logic [PW-1:0]    smx_ff;
   logic [PW-1:0]    smy_ff;
   logic [F-1:0]     sx_ff [3:7];
   logic [F-1:0]     sy_ff [3:9];
   // stage 4..7, corners ordered {y, x}
   logic [31:0]      g4_ff [0:3];
   logic [31:0]      g5_ff [0:3];
   logic [31:0]      g6_ff [0:3];
   logic [31:0]      g7_ff [0:3];
   // blend
   logic [31:0]      v [0:3];
   logic [MW-1:0]    m8_ff [0:3];
   logic [MW:0]      top_sum;
   logic [MW:0]      bot_sum;
   logic [31:0]      top9_ff;
   logic [31:0]      bot9_ff;
   logic [MW-1:0]    m10_ff [0:1];
   logic [MW:0]      fin_sum;
   logic [NOISE_W-1:0] out_ff [0:PAD];

   // Scale by 2^OCTAVE and split into cell index and fraction
   assign px = {{32{x_coord[COORD_W-1]}}, x_coord} << OCTAVE;
   assign py = {{32{y_coord[COORD_W-1]}}, y_coord} << OCTAVE;
   assign ix = px[F +: 32];
   assign iy = py[F +: 32];
   assign tx = px[F-1:0];
   assign ty = py[F-1:0];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         v[c] = fold16(g7_ff[c]);
      end
   end

   assign top_sum = {1'b0, m8_ff[0]} + {1'b0, m8_ff[1]};
   assign bot_sum = {1'b0, m8_ff[2]} + {1'b0, m8_ff[3]};
   assign fin_sum = {1'b0, m10_ff[0]} + {1'b0, m10_ff[1]};

   always_ff @(posedge clock) begin
      // stage 1: index products, salt product, fraction squares
      ax_ff[0]    <= ix * MIX_A;
      ax_ff[1]    <= (ix + 32'd1) * MIX_A;
      by_ff[1][0] <= iy * MIX_B;
      by_ff[1][1] <= (iy + 32'd1) * MIX_B;
      salt_ff[1]  <= (noise_salt + OCT_SALT) * MIX_S;
      ttx_ff      <= TW'(tx) * TW'(tx);
      tty_ff      <= TW'(ty) * TW'(ty);
      tx_ff       <= tx;
      ty_ff       <= ty;
      // stage 2
      hx2_ff[0] <= mix_lo(ax_ff[0]);
      hx2_ff[1] <= mix_lo(ax_ff[1]);
      smx_ff    <= PW'(ttx_ff[TW-1:F]) * PW'(THREE_F - KW'({tx_ff, 1'b0}));
      smy_ff    <= PW'(tty_ff[TW-1:F]) * PW'(THREE_F - KW'({ty_ff, 1'b0}));
      // stage 3
      hx3_ff[0] <= mix_hi(hx2_ff[0]);
      hx3_ff[1] <= mix_hi(hx2_ff[1]);
      sx_ff[3]  <= smx_ff[F +: F];
      sy_ff[3]  <= smy_ff[F +: F];
      // stage 4: mix in y
      g4_ff[0] <= mix_lo(fold16(hx3_ff[0]) ^ by_ff[3][0]);
      g4_ff[1] <= mix_lo(fold16(hx3_ff[1]) ^ by_ff[3][0]);
      g4_ff[2] <= mix_lo(fold16(hx3_ff[0]) ^ by_ff[3][1]);
      g4_ff[3] <= mix_lo(fold16(hx3_ff[1]) ^ by_ff[3][1]);
      for (int c = 0; c < 4; c++) begin
         g5_ff[c] <= mix_hi(g4_ff[c]);
         g6_ff[c] <= mix_lo(fold16(g5_ff[c]) ^ salt_ff[5]);
         g7_ff[c] <= mix_hi(g6_ff[c]);
      end
      // stage 8: horizontal blend products
      m8_ff[0] <= MW'(v[0]) * MW'(ONE_W - WW'(sx_ff[7]));
      m8_ff[1] <= MW'(v[1]) * MW'(sx_ff[7]);
      m8_ff[2] <= MW'(v[2]) * MW'(ONE_W - WW'(sx_ff[7]));
      m8_ff[3] <= MW'(v[3]) * MW'(sx_ff[7]);
      top9_ff  <= top_sum[F +: 32];
      bot9_ff  <= bot_sum[F +: 32];
      // vertical blend
      m10_ff[0] <= MW'(top9_ff) * MW'(ONE_W - WW'(sy_ff[9]));
      m10_ff[1] <= MW'(bot9_ff) * MW'(sy_ff[9]);
      out_ff[0] <= fin_sum[F +: 32];
      // delay lines
      for (int k = 2; k <= 3; k++) begin
         by_ff[k] <= by_ff[k-1];
      end
      for (int k = 2; k <= 5; k++) begin
         salt_ff[k] <= salt_ff[k-1];
      end
      for (int k = 4; k <= 7; k++) begin
         sx_ff[k] <= sx_ff[k-1];
      end
      for (int k = 4; k <= 9; k++) begin
         sy_ff[k] <= sy_ff[k-1];
      end
      for (int k = 1; k <= PAD; k++) begin
         out_ff[k] <= out_ff[k-1];
      end
   end

   assign noise = out_ff[PAD];

endmodule

`default_nettype wire

/* rtl/core/hvn_div.sv */
`default_nettype none

module hvn_div import hvn_pkg::*; #(
   parameter int NUM_W = 52,
   parameter int DEN_W = 20
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [OUT_W-1:0] quotient
);

   // Quotient = num / (den << OUT_W), known to fit OUT_W bits; one bit a stage.
   localparam int QW = OUT_W;

   logic [NUM_W-1:0] rem_ff [1:QW];
   logic [DEN_W-1:0] den_ff [1:QW];
   logic [QW-1:0]    quo_ff [1:QW];

   for (genvar j = 1; j <= QW; j++) begin : g_stage
      localparam int B = QW - j;
      logic [NUM_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [QW-1:0]    quo_src;
      logic [NUM_W-1:0] shifted;

      if (j == 1) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign den_src = den_ff[j-1];
         assign quo_src = quo_ff[j-1];
      end

      assign shifted = NUM_W'(den_src) << (QW + B);

      always_ff @(posedge clock) begin
         if (rem_src >= shifted) begin
            rem_ff[j] <= rem_src - shifted;
            quo_ff[j] <= quo_src | (QW'(1) << B);
         end else begin
            rem_ff[j] <= rem_src;
            quo_ff[j] <= quo_src;
         end
         den_ff[j] <= den_src;
      end
   end

   assign quotient = quo_ff[QW];

endmodule

`default_nettype wire

/* rtl/core/hashed_value_noise_fbm_unit.sv */
// Path from start to rsp_strobe: the padded octave lanes, the weighted-product registers, the
//   adder tree and the divider, with the valid pipeline running alongside.
// Throughput: one transaction per cycle; busy is never raised and every stage is a plain
//   register stage, so the receiver cannot and need not stall the pipeline.
// Reset: synchronous, active high; clears the valid pipeline and loads the register
//   defaults (octave_count 3, octave_gain 36045, noise_salt 0).
`default_nettype none

module hashed_value_noise_fbm_unit import hvn_pkg::*; #(
   parameter int MAX_OCTAVES = 8,
   parameter int FRAC_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // command channel
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_x_coord,
   input  logic signed [COORD_W-1:0] req_y_coord,
   // result channel
   output logic                      rsp_strobe,
   output logic [OUT_W-1:0]          rsp_noise_value,
   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [ADDR_W-1:0]         paddr,
   input  logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]         prdata,
   output logic                      pready
);

   // Noise lanes are padded so the amplitude chain has settled when products are taken.
   localparam int LAT_N  = (MAX_OCTAVES > OCT_DEPTH) ? MAX_OCTAVES : OCT_DEPTH;
   localparam int PAD    = LAT_N - OCT_DEPTH;
   localparam int LV     = $clog2(MAX_OCTAVES);
   localparam int NL     = 1 << LV;
   localparam int SUM_W  = PROD_W + LV;
   localparam int NORM_W = AMP_W + LV;
   localparam int LAT    = LAT_N + 1 + LV + OUT_W;
   localparam logic [4:0] MAX_C = 5'(MAX_OCTAVES);

   // Configuration registers
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [SALT_W-1:0]  salt_ff, salt_in;
   logic               csr_write;
   reg_index_type      csr_index;

   logic               accept;
   logic [LAT:1]       valid_ff;
   logic [LAT:1]       valid_in;
   logic [4:0]         count_sat;

   logic [AMP_W-1:0]   amp_ff [0:MAX_OCTAVES-1];
   logic [NOISE_W-1:0] noise [0:MAX_OCTAVES-1];
   logic [SUM_W-1:0]   sum_tree_ff [0:LV][0:NL-1];
   logic [NORM_W-1:0]  norm_tree_ff [0:LV][0:NL-1];

   // ---------------------------------------------------------------------------------
   // Register port: zero-wait writes on the access phase, combinational read-back.
   // ---------------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[ADDR_W-1:2]);

   always_comb begin
      count_in = count_ff;
      gain_in  = gain_ff;
      salt_in  = salt_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_OCTAVE_COUNT: count_in = pwdata[COUNT_W-1:0];
            REG_OCTAVE_GAIN:  gain_in  = pwdata[GAIN_W-1:0];
            REG_NOISE_SALT:   salt_in  = pwdata[SALT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_OCTAVE_COUNT: prdata = DATA_W'(count_ff);
         REG_OCTAVE_GAIN:  prdata = DATA_W'(gain_ff);
         REG_NOISE_SALT:   prdata = DATA_W'(salt_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         gain_ff  <= GAIN_RESET;
         salt_ff  <= SALT_RESET;
      end else begin
         count_ff <= count_in;
         gain_ff  <= gain_in;
         salt_ff  <= salt_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Transaction valid pipeline: one bit per stage, travels with the data.
   // ---------------------------------------------------------------------------------
   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign valid_in = {valid_ff[LAT-1:1], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Octave count clamped to 1..MAX_OCTAVES
   always_comb begin
      priority if (count_ff == '0) begin
         count_sat = 5'd1;
      end else if ({1'b0, count_ff} > MAX_C) begin
         count_sat = MAX_C;
      end else begin
         count_sat = {1'b0, count_ff};
      end
   end

   // ---------------------------------------------------------------------------------
   // Amplitude chain: amp[k] = amp[k-1] * gain >> 16, one multiply per register.
   // It depends on the gain register only, and after a write it settles before any transaction
   // accepted from that write on reaches the product stage.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      amp_ff[0] <= AMP_ONE;
   end

   for (genvar k = 1; k < MAX_OCTAVES; k++) begin : g_amp
      logic [AMP_W+GAIN_W-1:0] amp_mul;
      assign amp_mul = (AMP_W+GAIN_W)'(amp_ff[k-1]) * (AMP_W+GAIN_W)'(gain_ff);
      always_ff @(posedge clock) begin
         amp_ff[k] <= amp_mul[GAIN_W +: AMP_W];
      end
   end

   // ---------------------------------------------------------------------------------
   // One lattice-noise lane per octave, all running side by side.
   // ---------------------------------------------------------------------------------
   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
      hvn_octave #(
         .FRAC_BITS (FRAC_BITS),
         .OCTAVE    (i),
         .PAD       (PAD)
      ) u_octave (
         .clock      (clock),
         .x_coord    (req_x_coord),
         .y_coord    (req_y_coord),
         .noise_salt (salt_ff),
         .noise      (noise[i])
      );
   end

   // ---------------------------------------------------------------------------------
   // Weighted products (drop octaves past the count), then a registered adder tree
   // for both the weighted sum and the weight sum.
   // ---------------------------------------------------------------------------------
   for (genvar n = 0; n < NL; n++) begin : g_leaf
      if (n < MAX_OCTAVES) begin : g_live
         always_ff @(posedge clock) begin
            if (5'(n) < count_sat) begin
               sum_tree_ff[0][n]  <= SUM_W'(PROD_W'(amp_ff[n]) * PROD_W'(noise[n]));
               norm_tree_ff[0][n] <= NORM_W'(amp_ff[n]);
            end else begin
               sum_tree_ff[0][n]  <= '0;
               norm_tree_ff[0][n] <= '0;
            end
         end
      end else begin : g_dead
         always_ff @(posedge clock) begin
            sum_tree_ff[0][n]  <= '0;
            norm_tree_ff[0][n] <= '0;
         end
      end
   end

   for (genvar l = 1; l <= LV; l++) begin : g_level
      for (genvar n = 0; n < NL; n++) begin : g_node
         if (n < (NL >> l)) begin : g_add
            always_ff @(posedge clock) begin
               sum_tree_ff[l][n]  <= sum_tree_ff[l-1][2*n] + sum_tree_ff[l-1][2*n+1];
               norm_tree_ff[l][n] <= norm_tree_ff[l-1][2*n] + norm_tree_ff[l-1][2*n+1];
            end
         end else begin : g_zero
            always_ff @(posedge clock) begin
               sum_tree_ff[l][n]  <= '0;
               norm_tree_ff[l][n] <= '0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Normalize: sum / (norm << 16), one quotient bit per stage.
   // ---------------------------------------------------------------------------------
   hvn_div #(
      .NUM_W (SUM_W),
      .DEN_W (NORM_W)
   ) u_div (
      .clock    (clock),
      .num      (sum_tree_ff[LV][0]),
      .den      (norm_tree_ff[LV][0]),
      .quotient (rsp_noise_value)
   );

   assign rsp_strobe = valid_ff[LAT];

endmodule

`default_nettype wire

/* rtl/core/hvn_checker.sv */
`default_nettype none

module hvn_checker import hvn_pkg::*; #(
   parameter int LAT = 31
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic              psel,
   input logic              penable,
   input logic              pwrite,
   input logic [ADDR_W-1:0] paddr,
   input logic [DATA_W-1:0] pwdata,
   input logic [DATA_W-1:0] prdata,
   input logic              pready
);

   // Every accepted transaction yields a result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("accepted transaction produced no result");

   // No result without a transaction accepted the fixed latency earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result strobe without matching transaction");

   // Octave count write is read back on the next cycle
   a_count_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_OCTAVE_COUNT))
      |=> ((paddr[ADDR_W-1:2] != REG_OCTAVE_COUNT) ||
           (prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0]))))
      else $error("octave count read-back mismatch");

   // Port is always ready and never refuses a transaction
   a_always_ready: assert property (@(posedge clock) disable iff (reset)
      pready && !busy)
      else $error("ready dropped or busy raised");

endmodule

bind hashed_value_noise_fbm_unit hvn_checker #(
   .LAT (LAT)
) u_hvn_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .psel       (psel),
   .penable    (penable),
   .pwrite     (pwrite),
   .paddr      (paddr),
   .pwdata     (pwdata),
   .prdata     (prdata),
   .pready     (pready)
);

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

import hvn_pkg::*;

// Scoreboard: holds the register image, predicts each accepted point and
// checks every result strobe against the oldest prediction.
class noise_scoreboard;
   localparam int FRAC    = 16;
   localparam int OCT_MAX = 8;

   logic [3:0]  count_q;
   logic [15:0] gain_q;
   logic [31:0] salt_q;
   logic [15:0] pending_noise[$];
   int          mismatches;
   int          checked;

   function new();
      count_q     = COUNT_RESET;
      gain_q      = GAIN_RESET;
      salt_q      = SALT_RESET;
      mismatches  = 0;
      checked     = 0;
   endfunction

   function void set_reg(reg_index_type idx, logic [31:0] value);
      case (idx)
         REG_OCTAVE_COUNT: count_q = value[3:0];
         REG_OCTAVE_GAIN:  gain_q  = value[15:0];
         REG_NOISE_SALT:   salt_q  = value;
         default: ;
      endcase
   endfunction

   function logic [31:0] avalanche(logic [31:0] v);
      logic [31:0] w;
      w = v ^ (v >> 16);
      w = w * HASH_M1;
      w = w ^ (w >> 15);
      w = w * HASH_M2;
      return w ^ (w >> 16);
   endfunction

   function logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy, logic [31:0] salt);
      logic [31:0] h;
      logic [31:0] m;
      m = cx * MIX_A;
      h = avalanche(m);
      m = cy * MIX_B;
      h = avalanche(h ^ m);
      m = salt * MIX_S;
      return avalanche(h ^ m);
   endfunction

   function logic [63:0] fade(logic [63:0] t);
      logic [63:0] t2;
      t2 = (t * t) >> FRAC;
      return (t2 * ((64'd3 << FRAC) - 2 * t)) >> FRAC;
   endfunction

   function logic [63:0] mix(logic [63:0] p, logic [63:0] q, logic [63:0] s);
      return (p * ((64'd1 << FRAC) - s) + q * s) >> FRAC;
   endfunction

   function logic [63:0] octave_noise(logic [63:0] px, logic [63:0] py, logic [31:0] salt);
      logic [63:0] tmp;
      logic [31:0] ix, iy, ix1, iy1;
      logic [63:0] sx, sy, top, bot;
      tmp = px >> FRAC;
      ix  = tmp[31:0];
      tmp = py >> FRAC;
      iy  = tmp[31:0];
      ix1 = ix + 32'd1;
      iy1 = iy + 32'd1;
      sx  = fade(px & 64'hFFFF);
      sy  = fade(py & 64'hFFFF);
      top = mix({32'd0, lattice_hash(ix, iy, salt)}, {32'd0, lattice_hash(ix1, iy, salt)}, sx);
      bot = mix({32'd0, lattice_hash(ix, iy1, salt)},
                {32'd0, lattice_hash(ix1, iy1, salt)}, sx);
      return mix(top, bot, sy);
   endfunction

   // Note one accepted point and queue its expected noise value.
   function void note_point(logic signed [31:0] x, logic signed [31:0] y);
      logic [63:0] xs, ys, amp, acc, norm, q;
      int          n;
      logic [31:0] salt;
      xs  = {{32{x[31]}}, x};
      ys  = {{32{y[31]}}, y};
      n   = (count_q < 1) ? 1 : (count_q > OCT_MAX) ? OCT_MAX : count_q;
      amp = 64'd65536;
      acc = 0;
      norm = 0;
      for (int i = 0; i < n; i++) begin
         salt = salt_q + i * SALT_STEP;
         acc  = acc + amp * octave_noise(xs << i, ys << i, salt);
         norm = norm + amp;
         amp  = (amp * gain_q) >> 16;
      end
      q = acc / (norm << 16);
      pending_noise = {pending_noise, q[15:0]};
   endfunction

   // Check one result strobe against the oldest expectation.
   function void check_noise(logic [15:0] got);
      logic [15:0] want;
      checked++;
      if (pending_noise.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: result %h with no transaction outstanding", got);
         return;
      end
      want = pending_noise.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: noise_value expected %h got %h", want, got);
      end
   endfunction
endclass

module tb;
   localparam int LATENCY     = 31;
   localparam int CYCLE_LIMIT = 400000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_x_coord;
   logic signed [31:0] req_y_coord;
   logic               rsp_strobe;
   logic [15:0]        rsp_noise_value;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [ADDR_W-1:0]  paddr;
   logic [DATA_W-1:0]  pwdata;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   noise_scoreboard sb;
   int              cycles;
   int              sent;
   int              idle_pct;

   hashed_value_noise_fbm_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .rsp_strobe(rsp_strobe), .rsp_noise_value(rsp_noise_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: end the run if the pipeline hangs.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("** hashed_value_noise_fbm_unit: FAILED **");
         $finish;
      end
   end

   // Results cannot be held off: check every strobe at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_noise(rsp_noise_value);
   end

   // Write one register through a setup and an access cycle.
   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_W'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   // Issue one point; start stays high if the next transaction follows at once.
   task automatic send_point(logic [31:0] x, logic [31:0] y);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (busy);
      sb.note_point(x, y);
      sent++;
   endtask

   // Drain the pipeline so the registers can be changed safely.
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_noise.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(5))
         0: return {16'($urandom_range(31) - 16), 16'($urandom)};  // near the origin
         1: return {16'($urandom), 16'h0000};                      // on a cell edge
         2: return {16'($urandom), 16'hFFFF};                      // just below an edge
         3: return $urandom_range(1) ? 32'h7FFF0000 | $urandom_range(65535)
                                     : 32'h80000000 | $urandom_range(65535);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_points(int n);
      for (int i = 0; i < n; i++) begin
         // Sweep sender idling: 28%, then 51%, then none.
         idle_pct = (sent < 370) ? 28 : (sent < 740) ? 51 : 0;
         if ($urandom_range(15) == 0) idle_pct = 0;
         send_point(pick_coord(), pick_coord());
      end
   endtask

   logic [31:0] edge_vals[10] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                                  32'h1, 32'h0000FFFF, 32'h00010000, 32'hFFFF0000,
                                  32'h7FFF0000, 32'h55555555};

   initial begin
      sb          = new();
      sent        = 0;
      idle_pct    = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_x_coord = '0;
      req_y_coord = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes and cell boundaries at reset settings.
      for (int i = 0; i < 10; i++)
         send_point(edge_vals[i], edge_vals[9 - i]);
      send_point(32'h80000000, 32'h80000000);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
      drain();

      // Zero octaves acts as one; zero gain keeps only the base octave.
      write_reg(REG_OCTAVE_COUNT, 32'd0);
      write_reg(REG_OCTAVE_GAIN, 32'd0);
      write_reg(REG_NOISE_SALT, 32'hFFFFFFFF);
      for (int i = 0; i < 4; i++) send_point(edge_vals[i], edge_vals[i + 4]);
      drain();
      write_reg(REG_OCTAVE_COUNT, 32'd15);     // saturates at the octave limit
      write_reg(REG_OCTAVE_GAIN, 32'hFFFF);
      for (int i = 0; i < 4; i++) send_point(edge_vals[i + 4], edge_vals[i]);
      random_points(180);
      drain();

      write_reg(REG_OCTAVE_COUNT, 32'd1);
      write_reg(REG_OCTAVE_GAIN, 32'd0);
      write_reg(REG_NOISE_SALT, 32'h0);
      random_points(180);
      drain();

      write_reg(REG_OCTAVE_COUNT, 32'd8);
      write_reg(REG_OCTAVE_GAIN, 32'd1);
      write_reg(REG_NOISE_SALT, 32'hFFFFFFFF - 32'd7919);
      random_points(180);
      drain();

      // Random settings for three phases.
      for (int p = 0; p < 3; p++) begin
         write_reg(REG_OCTAVE_COUNT, $urandom_range(15));
         write_reg(REG_OCTAVE_GAIN, $urandom);
         write_reg(REG_NOISE_SALT, $urandom);
         random_points(180);
         drain();
      end

      write_reg(REG_OCTAVE_COUNT, 32'd3);
      write_reg(REG_OCTAVE_GAIN, 32'd36045);
      write_reg(REG_NOISE_SALT, 32'h0);
      random_points(30);
      drain();

      if (sb.pending_noise.size() != 0) begin
         sb.mismatches++;
         $display("ERROR: %0d expected results never arrived", sb.pending_noise.size());
      end
      $display("Sent %0d points and checked %0d results over %0d cycles,", sent,
               sb.checked, cycles);
      $display("covering octave counts 0..15, gains 0..65535 and salts at both ends.");
      if (sb.mismatches == 0)
         $display("** hashed_value_noise_fbm_unit: PASSED **");
      else
         $display("** hashed_value_noise_fbm_unit: FAILED **");
      $finish;
   end
endmodule
